/* rtl/core/edf_arb_pkg.sv */
// Shared types and constants for the EDF/FIFO resource arbiter.
// No dependencies; imported by the arbiter top level and the bench.
`default_nettype none

package edf_arb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 8;
  localparam int TIME_W  = 32;
  localparam int KEY_W   = TIME_W + 1;
  localparam int ENTRY_W = KEY_W + ID_W;
  localparam int WAIT_W  = 5;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_CANCEL  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_EDF_MODE = 2'd0,
    CFG_BURNOUT  = 2'd1,
    CFG_COOLDOWN = 2'd2
  } cfg_idx_t;

  localparam logic [TIME_W-1:0] BURNOUT_RST  = 32'd1000;
  localparam logic [TIME_W-1:0] COOLDOWN_RST = 32'd0;

endpackage

`default_nettype wire

/* rtl/core/edf_arb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module edf_arb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/edf_fifo_resource_arbiter_unit.sv */
// Top level of the EDF/FIFO arbiter for one shared resource.
// Depends on edf_arb_pkg and edf_arb_ram.
`default_nettype none

// The block guards one shared resource. Each input word on the in_ channel
// carries a function in in_tuser (request, release, time tick or cancel) and
// the requester id and times in in_tdata. For every input word exactly one
// result word leaves on the out_ channel: grant flag and id, whether the
// resource is held, the number of waiting requesters and an overflow flag.
// The cfg_ channel writes the mode, burnout time and cooldown time; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. A request, release or tick without a
// grant passes through the execute, grant-check and done states to its
// result, and the block is ready again once it is back in idle. A cancel
// and a grant each add a scan of the queue, and each removal adds a read
// and a write state that move the last entry into the freed slot. The
// queue RAM has a single read port, so the scan walks it one entry a cycle.
// The block takes one word at a time. A finished result sits in the output
// register while the next word is accepted; the block stalls before its
// own result only if the previous one has still not been taken.
// Reset empties the queue, frees the resource, clears the cooldown and
// loads the register defaults; the queue RAM needs no clearing.
module edf_fifo_resource_arbiter_unit
  import edf_arb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [7:0] requester_id, [39:8] time_now, [71:40] last_done_time
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] granted, [8:1] grant_id, [9] busy_res, [14:10] waiting, [15] overflow
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [TIME_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_GCHK, S_SCAN, S_RM_RD, S_RM_WR, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              edf_mode_r, edf_mode_nxt;
  logic [TIME_W-1:0] burnout_r, burnout_nxt;
  logic [TIME_W-1:0] cooldown_r, cooldown_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              held_r, held_nxt;
  logic [KEY_W-1:0]  cd_end_r, cd_end_nxt;
  func_t             func_r, func_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic              scan_min_r, scan_min_nxt;
  logic              rm_grant_r, rm_grant_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic              granted_r, granted_nxt;
  logic [ID_W-1:0]   gid_r, gid_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [KEY_W-1:0]   new_key;
  logic [CW-1:0]      last_idx;
  logic [KEY_W-1:0]   rd_key;
  logic [ID_W-1:0]    rd_id;
  logic               can_grant;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign new_key   = edf_mode_r ? ({1'b0, last_r} + {1'b0, burnout_r}) : {1'b0, now_r};
  assign last_idx  = cnt_r - CW'(1);
  assign rd_key    = ram_rdata[ENTRY_W-1:ID_W];
  assign rd_id     = ram_rdata[ID_W-1:0];
  assign can_grant = (cnt_r != '0) && !held_r && ({1'b0, now_r} >= cd_end_r);

  edf_arb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    edf_mode_nxt = edf_mode_r;
    burnout_nxt  = burnout_r;
    cooldown_nxt = cooldown_r;
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    cd_end_nxt   = cd_end_r;
    func_nxt     = func_r;
    rid_nxt      = rid_r;
    now_nxt      = now_r;
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    pvalid_nxt   = pvalid_r;
    scan_min_nxt = scan_min_r;
    rm_grant_nxt = rm_grant_r;
    pos_nxt      = pos_r;
    best_key_nxt = best_key_r;
    best_id_nxt  = best_id_r;
    granted_nxt  = granted_r;
    gid_nxt      = gid_r;
    ovf_nxt      = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {new_key, rid_r};
    ram_raddr = idx_r[AW-1:0];

    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EDF_MODE: edf_mode_nxt = cfg_data[0];
        CFG_BURNOUT:  burnout_nxt  = cfg_data;
        CFG_COOLDOWN: cooldown_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt    = func_t'(in_tuser);
          rid_nxt     = in_tdata[7:0];
          now_nxt     = in_tdata[39:8];
          last_nxt    = in_tdata[71:40];
          granted_nxt = 1'b0;
          gid_nxt     = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_GCHK;
        case (func_r)
          FUNC_REQUEST: begin
            if (cnt_r >= CW'(QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          FUNC_RELEASE: begin
            held_nxt   = 1'b0;
            cd_end_nxt = {1'b0, now_r} + {1'b0, cooldown_r};
          end
          FUNC_CANCEL: begin
            scan_min_nxt = 1'b0;
            idx_nxt      = '0;
            pvalid_nxt   = 1'b0;
            state_nxt    = S_SCAN;
          end
          default: ;
        endcase
      end
      S_GCHK: begin
        if (can_grant) begin
          scan_min_nxt = 1'b1;
          idx_nxt      = '0;
          pvalid_nxt   = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        ram_raddr  = idx_r[AW-1:0];
        pidx_nxt   = idx_r[AW-1:0];
        pvalid_nxt = (idx_r < cnt_r);
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pvalid_r) begin
          if (scan_min_r) begin
            if ((pidx_r == '0) || (rd_key < best_key_r)) begin
              best_key_nxt = rd_key;
              best_id_nxt  = rd_id;
              pos_nxt      = pidx_r;
            end
          end else if (rd_id == rid_r) begin
            pos_nxt      = pidx_r;
            rm_grant_nxt = 1'b0;
            state_nxt    = S_RM_RD;
          end
        end else if (idx_r >= cnt_r) begin
          if (scan_min_r) begin
            rm_grant_nxt = 1'b1;
            state_nxt    = S_RM_RD;
          end else begin
            state_nxt = S_GCHK;
          end
        end
      end
      S_RM_RD: begin
        ram_raddr = last_idx[AW-1:0];
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = ram_rdata;
        cnt_nxt   = last_idx;
        if (rm_grant_r) begin
          held_nxt    = 1'b1;
          granted_nxt = 1'b1;
          gid_nxt     = best_id_r;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_GCHK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ovf_r, WAIT_W'(cnt_r), held_r, gid_r, granted_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edf_mode_r  <= 1'b0;
      burnout_r   <= BURNOUT_RST;
      cooldown_r  <= COOLDOWN_RST;
      cnt_r       <= '0;
      held_r      <= 1'b0;
      cd_end_r    <= '0;
      idx_r       <= '0;
      pvalid_r    <= 1'b0;
      scan_min_r  <= 1'b0;
      rm_grant_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edf_mode_r  <= edf_mode_nxt;
      burnout_r   <= burnout_nxt;
      cooldown_r  <= cooldown_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      cd_end_r    <= cd_end_nxt;
      idx_r       <= idx_nxt;
      pvalid_r    <= pvalid_nxt;
      scan_min_r  <= scan_min_nxt;
      rm_grant_r  <= rm_grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    rid_r      <= rid_nxt;
    now_r      <= now_nxt;
    last_r     <= last_nxt;
    pidx_r     <= pidx_nxt;
    pos_r      <= pos_nxt;
    best_key_r <= best_key_nxt;
    best_id_r  <= best_id_nxt;
    granted_r  <= granted_nxt;
    gid_r      <= gid_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the EDF/FIFO resource arbiter: a queue-fed driver,
// a stalling receiver and a grant predictor that tracks the queue and cooldown.
// Depends on edf_arb_pkg and the edf_fifo_resource_arbiter_unit RTL.
`timescale 1ns / 1ps

module tb
  import edf_arb_pkg::*;
();

  typedef struct {
    func_t             func;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] last_done;
    bit                drain;
  } arb_word_t;

  typedef struct packed {
    logic              overflow;
    logic [WAIT_W-1:0] waiting;
    logic              busy_res;
    logic [ID_W-1:0]   grant_id;
    logic              granted;
  } arb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  arb_word_t   pending_words[$];
  arb_result_t due_results[$];
  int words_queued = 0;
  int words_taken = 0;
  int mismatches = 0;
  int in_gap = 0;
  int in_gap_max = 0;
  int out_wait = 0;
  int out_stall_max = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic cfg_fire = 1'b0;

  // Predicted arbiter state.
  logic              edf_mode = 1'b0;
  logic [TIME_W-1:0] burnout = BURNOUT_RST;
  logic [TIME_W-1:0] cooldown = COOLDOWN_RST;
  logic [ID_W-1:0]   q_ids[QUEUE_DEPTH];
  logic [KEY_W-1:0]  q_keys[QUEUE_DEPTH];
  int                q_count = 0;
  logic              res_held = 1'b0;
  logic [KEY_W-1:0]  cool_end = '0;

  edf_fifo_resource_arbiter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The last entry moves into the freed slot.
  function automatic void drop_slot(int pos);
    q_ids[pos] = q_ids[q_count-1];
    q_keys[pos] = q_keys[q_count-1];
    q_count--;
  endfunction

  function automatic arb_result_t grant_step(func_t f, logic [ID_W-1:0] rid,
                                             logic [TIME_W-1:0] now,
                                             logic [TIME_W-1:0] last_done);
    arb_result_t r;
    int i;
    int found;
    int best;
    r = '0;
    found = -1;
    case (f)
      FUNC_REQUEST: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          q_ids[q_count] = rid;
          q_keys[q_count] = edf_mode ? {1'b0, last_done} + {1'b0, burnout} : {1'b0, now};
          q_count++;
        end
      end
      FUNC_RELEASE: begin
        res_held = 1'b0;
        cool_end = {1'b0, now} + {1'b0, cooldown};
      end
      FUNC_CANCEL: begin
        for (i = 0; i < q_count; i++)
          if (found < 0 && q_ids[i] == rid) found = i;
        if (found >= 0) drop_slot(found);
      end
      default: ;
    endcase
    if (q_count > 0 && !res_held && {1'b0, now} >= cool_end) begin
      best = 0;
      for (i = 1; i < q_count; i++)
        if (q_keys[i] < q_keys[best]) best = i;
      r.granted = 1'b1;
      r.grant_id = q_ids[best];
      drop_slot(best);
      res_held = 1'b1;
    end
    r.busy_res = res_held;
    r.waiting = WAIT_W'(q_count);
    return r;
  endfunction

  // Handshakes are sampled here; the predictor advances on every accepted word.
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n && in_tvalid && in_tready) begin
      due_results.push_back(grant_step(func_t'(in_tuser), in_tdata[7:0], in_tdata[39:8],
                                       in_tdata[71:40]));
      words_taken++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EDF_MODE: edf_mode = cfg_data[0];
        CFG_BURNOUT:  burnout = cfg_data;
        CFG_COOLDOWN: cooldown = cfg_data;
        default: ;
      endcase
    end
  end

  always @(negedge clk) begin
    logic nv;
    arb_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid && !in_fire;
      if (in_fire) in_gap = $urandom_range(0, in_gap_max);
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && due_results.size() != 0)) begin
          w = pending_words.pop_front();
          in_tuser <= w.func;
          in_tdata <= {w.last_done, w.now, w.id};
          nv = 1'b1;
        end
      end
      in_tvalid <= nv;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end
    if (out_fire) out_wait = $urandom_range(0, out_stall_max);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    arb_result_t want;
    arb_result_t got;
    out_fire <= out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = arb_result_t'(out_tdata);
      if (due_results.size() == 0) begin
        $error("result word %h arrived with none expected", out_tdata);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, got.granted);
          mismatches++;
        end
        if (got.grant_id !== want.grant_id) begin
          $error("grant_id: expected %0d, got %0d", want.grant_id, got.grant_id);
          mismatches++;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
          mismatches++;
        end
        if (got.waiting !== want.waiting) begin
          $error("waiting: expected %0d, got %0d", want.waiting, got.waiting);
          mismatches++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
          mismatches++;
        end
      end
    end
  end

  task automatic add_word(func_t f, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                          logic [TIME_W-1:0] last_done);
    arb_word_t w;
    w.func = f;
    w.id = id;
    w.now = now;
    w.last_done = last_done;
    w.drain = 1'b0;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (words_taken != words_queued || due_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int req_pct, int gap_max, int stall_max, bit long_hold);
    logic [TIME_W-1:0] t;
    int roll;
    int k;
    int share;
    arb_word_t w;
    in_gap_max = gap_max;
    out_stall_max = stall_max;
    share = (100 - req_pct) / 3;
    t = $urandom;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      w.drain = (k == n / 2);
      if (roll < 10) begin
        w.func = func_t'($urandom_range(0, 3));
        w.id = ID_W'($urandom);
        w.now = $urandom;
        w.last_done = $urandom;
      end else begin
        t = t + $urandom_range(0, 8);
        roll = $urandom_range(0, 99);
        if (roll < req_pct) w.func = FUNC_REQUEST;
        else if (roll < req_pct + share) w.func = FUNC_RELEASE;
        else if (roll < req_pct + 2 * share) w.func = FUNC_TICK;
        else w.func = FUNC_CANCEL;
        w.id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
        w.now = t;
        w.last_done = t - $urandom_range(0, 2000);
      end
      pending_words.push_back(w);
      words_queued++;
    end
    if (long_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_gap_max = 3;
    out_stall_max = 3;
    add_word(FUNC_REQUEST, 8'h00, 32'h0, 32'h0);
    add_word(FUNC_REQUEST, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (k = 1; k <= 15; k++)
      add_word(FUNC_REQUEST, (k == 12) ? 8'd3 : ID_W'(k),
               (k == 5 || k == 9) ? 32'd50 : 32'd1000 - k, 32'd7);
    add_word(FUNC_REQUEST, 8'h80, 32'd1, 32'd1);
    add_word(FUNC_CANCEL, 8'd3, 32'd2, 32'd0);
    add_word(FUNC_CANCEL, 8'hAA, 32'd2, 32'd0);
    add_word(FUNC_TICK, 8'd0, 32'd0, 32'd0);
    add_word(FUNC_RELEASE, 8'd0, 32'd60, 32'd0);
    add_word(FUNC_RELEASE, 8'd0, 32'd60, 32'd0);
    wait_idle();

    cfg_write(CFG_EDF_MODE, 32'd1);
    cfg_write(CFG_BURNOUT, 32'hFFFF_FFFF);
    cfg_write(CFG_COOLDOWN, 32'hFFFF_FFFF);
    add_word(FUNC_REQUEST, 8'h42, 32'd0, 32'hFFFF_FFFF);
    add_word(FUNC_RELEASE, 8'd0, 32'd0, 32'd0);
    add_word(FUNC_TICK, 8'd0, 32'hFFFF_FFFE, 32'd0);
    add_word(FUNC_TICK, 8'd0, 32'hFFFF_FFFF, 32'd0);
    wait_idle();

    cfg_write(CFG_EDF_MODE, 32'd0);
    cfg_write(CFG_COOLDOWN, 32'd0);
    random_phase(160, 40, 0, 5, 1'b1);

    cfg_write(CFG_EDF_MODE, 32'd1);
    cfg_write(CFG_BURNOUT, $urandom_range(0, 50));
    cfg_write(CFG_COOLDOWN, $urandom_range(0, 20));
    random_phase(160, 40, 5, 5, 1'b0);

    cfg_write(CFG_BURNOUT, $urandom);
    cfg_write(CFG_COOLDOWN, 32'd0);
    random_phase(160, 60, 5, 0, 1'b0);

    cfg_write(CFG_EDF_MODE, 32'd0);
    cfg_write(CFG_BURNOUT, 32'd0);
    cfg_write(CFG_COOLDOWN, 32'hFFFF_FFFF);
    random_phase(160, 50, 0, 0, 1'b0);

    cfg_write(CFG_EDF_MODE, 32'd1);
    cfg_write(CFG_BURNOUT, 32'hFFFF_FFFF);
    cfg_write(CFG_COOLDOWN, $urandom_range(0, 5));
    random_phase(160, 35, 5, 5, 1'b0);

    cfg_write(CFG_EDF_MODE, 32'd0);
    cfg_write(CFG_BURNOUT, 32'd1000);
    cfg_write(CFG_COOLDOWN, $urandom);
    random_phase(160, 40, 2, 3, 1'b0);

    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/edf_arb_pkg.sv
rtl/core/edf_arb_ram.sv
rtl/core/edf_fifo_resource_arbiter_unit.sv
dv/tb.sv
